// ----- hw/rtl/srfr_pkg.sv -----
// ============================================================================
// srfr_pkg
// Shared types and constants for the stream find-and-replace block.
// ============================================================================
package srfr_pkg;

    localparam int BYTE_W     = 8;
    localparam int CFG_DATA_W = 64;
    localparam int CFG_ADDR_W = 2;
    localparam int LEN_W      = 4;

    localparam logic [CFG_ADDR_W-1:0] CFG_MATCH_BYTES   = 2'd0;
    localparam logic [CFG_ADDR_W-1:0] CFG_MATCH_LENGTH  = 2'd1;
    localparam logic [CFG_ADDR_W-1:0] CFG_REPLACE_BYTES = 2'd2;
    localparam logic [CFG_ADDR_W-1:0] CFG_REPLACE_LENGTH = 2'd3;

    // window cell control
    typedef struct packed {
        logic load;
        logic from_right;
        logic below_fill;
        logic at_fill;
    } win_ctl_t;

    // output queue cell control
    typedef struct packed {
        logic load;
        logic shift;
    } out_ctl_t;

endpackage

// ----- hw/rtl/srfr_win_cell.sv -----
// ============================================================================
// srfr_win_cell
// One byte of the pending window: loads, shifts from its right neighbor,
// and compares its byte against the pattern byte at the same position.
// ============================================================================
module srfr_win_cell
(
    input  logic                          clk,
    input  srfr_pkg::win_ctl_t            ctl,
    input  logic [srfr_pkg::BYTE_W-1:0]   in_byte,
    input  logic [srfr_pkg::BYTE_W-1:0]   right_byte,
    input  logic [srfr_pkg::BYTE_W-1:0]   pat_byte,
    output logic [srfr_pkg::BYTE_W-1:0]   byte_q,
    output logic                          hit
);

    logic [srfr_pkg::BYTE_W-1:0] byte_reg;
    logic [srfr_pkg::BYTE_W-1:0] byte_next;

    always_comb
    begin
        byte_next = byte_reg;
        if (ctl.load)
        begin
            byte_next = ctl.from_right ? right_byte : in_byte;
        end
    end

    always_ff @(posedge clk)
    begin
        byte_reg <= byte_next;
    end

    always_comb
    begin
        if (ctl.below_fill)
        begin
            hit = (byte_reg == pat_byte);
        end
        else if (ctl.at_fill)
        begin
            hit = (in_byte == pat_byte);
        end
        else
        begin
            hit = 1'b1;
        end
    end

    assign byte_q = byte_reg;

endmodule

// ----- hw/rtl/srfr_out_cell.sv -----
// ============================================================================
// srfr_out_cell
// One slot of the result queue: loads a result byte or takes the byte of
// its right neighbor as the head slot is consumed.
// ============================================================================
module srfr_out_cell
(
    input  logic                          clk,
    input  srfr_pkg::out_ctl_t            ctl,
    input  logic [srfr_pkg::BYTE_W-1:0]   load_byte,
    input  logic [srfr_pkg::BYTE_W-1:0]   right_byte,
    output logic [srfr_pkg::BYTE_W-1:0]   byte_q
);

    logic [srfr_pkg::BYTE_W-1:0] byte_reg;
    logic [srfr_pkg::BYTE_W-1:0] byte_next;

    always_comb
    begin
        byte_next = byte_reg;
        if (ctl.load)
        begin
            byte_next = load_byte;
        end
        else if (ctl.shift)
        begin
            byte_next = right_byte;
        end
    end

    always_ff @(posedge clk)
    begin
        byte_reg <= byte_next;
    end

    assign byte_q = byte_reg;

endmodule

// ----- hw/rtl/stream_find_replace_top.sv -----
// ============================================================================
// stream_find_replace_top
// Byte stream find and replace with a row of window cells and a shifting
// result queue.
// ============================================================================
// Each accepted byte is compared combinationally by a row of MAX_MATCH window
// cells. Its results are loaded into a queue of result cells, which hands one
// result per cycle, while m_tready is high or the output register is empty, to
// the output register that drives the m_ side. A byte that produces at most
// one result keeps the input at one byte per cycle while m_tready is high. A
// result waiting in the output register on m_tready still lets the next byte
// into the empty queue; after that, if that byte gave results, s_tready stays
// low until the output moves. A byte that produces n results (a replacement
// burst, or the flush at end of stream) holds s_tready low until the queue is
// down to its last entry. Configuration is taken at any time through the cfg
// channel and is meant to be written between streams.
module stream_find_replace_top
#(
    parameter int MAX_MATCH   = 8,
    parameter int MAX_REPLACE = 8
)
(
    input  logic                                clk,
    input  logic                                rst_n,

    input  logic                                s_tvalid,
    output logic                                s_tready,
    input  logic [srfr_pkg::BYTE_W-1:0]         s_tdata,   // [7:0] in_byte
    input  logic                                s_tlast,   // end_of_stream

    output logic                                m_tvalid,
    input  logic                                m_tready,
    output logic [srfr_pkg::BYTE_W-1:0]         m_tdata,   // [7:0] out_byte
    output logic [2:0]                          m_tuser,   // [0] byte_valid,
                                                           // [1] run_last,
                                                           // [2] any_match
    output logic                                m_tlast,   // stream_done

    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [srfr_pkg::CFG_ADDR_W-1:0]     cfg_addr,
    input  logic [srfr_pkg::CFG_DATA_W-1:0]     cfg_data
);

    localparam int BW = srfr_pkg::BYTE_W;
    localparam int QD = (MAX_MATCH > MAX_REPLACE) ? MAX_MATCH : MAX_REPLACE;
    localparam int FW = $clog2(MAX_MATCH + 1);
    localparam int CW = $clog2(QD + 1);

    logic [srfr_pkg::CFG_DATA_W-1:0] pat_bytes_reg;
    logic [srfr_pkg::LEN_W-1:0]      pat_len_reg;
    logic [srfr_pkg::CFG_DATA_W-1:0] rep_bytes_reg;
    logic [srfr_pkg::LEN_W-1:0]      rep_len_reg;

    logic [FW-1:0] fill_reg;
    logic [FW-1:0] fill_next;
    logic          seen_reg;
    logic          seen_next;
    logic [CW-1:0] cnt_reg;
    logic [CW-1:0] cnt_next;
    logic          empty_reg;
    logic          eos_reg;
    logic          any_reg;

    logic          out_valid_reg;
    logic [BW-1:0] out_data_reg;
    logic [2:0]    out_user_reg;
    logic          out_last_reg;

    logic          acc;
    logic          take;
    logic          q_valid;
    logic          head_last;
    logic          cfg_wr;
    logic [FW-1:0] len_eff;
    logic [CW-1:0] rep_eff;
    logic          pass;
    logic [FW-1:0] fpos;
    logic          full;
    logic          match_now;
    logic          shift;
    logic [CW-1:0] n_raw;
    logic          empty_now;

    srfr_pkg::win_ctl_t wctl [MAX_MATCH];
    logic [BW-1:0]      win_q [MAX_MATCH];
    logic [MAX_MATCH-1:0] hits;

    srfr_pkg::out_ctl_t octl;
    logic [BW-1:0]      oq    [QD];
    logic [BW-1:0]      cand  [QD];

    assign cfg_ready = 1'b1;
    assign cfg_wr    = cfg_valid & cfg_ready;
    assign q_valid   = (cnt_reg != '0);
    assign head_last = (cnt_reg == CW'(1));
    assign take      = q_valid & (!out_valid_reg | m_tready);
    assign s_tready  = (cnt_reg == '0) | (head_last & take);
    assign acc       = s_tvalid & s_tready;

    always_comb
    begin
        len_eff = (pat_len_reg > 4'(MAX_MATCH)) ? FW'(MAX_MATCH) : pat_len_reg[FW-1:0];
        rep_eff = (rep_len_reg > 4'(MAX_REPLACE)) ? CW'(MAX_REPLACE) : CW'(rep_len_reg);
        pass    = (len_eff == '0);
        fpos    = (fill_reg >= len_eff) ? '0 : fill_reg;
        full    = !pass && ((fpos + FW'(1)) == len_eff);
        match_now = full && (&hits);
        shift     = full && !match_now;
    end

    always_comb
    begin
        for (int i = 0; i < MAX_MATCH; i++)
        begin
            wctl[i].below_fill = (FW'(i) < fpos);
            wctl[i].at_fill    = (FW'(i) == fpos);
            wctl[i].load       = acc && !pass &&
                                 (shift ? (FW'(i) < fpos) : ((FW'(i) == fpos) && !full));
            wctl[i].from_right = shift && (FW'(i + 1) < fpos);
        end
    end

    for (genvar i = 0; i < MAX_MATCH; i++)
    begin : g_win
        logic [BW-1:0] right_byte;
        if (i == MAX_MATCH - 1)
        begin : g_edge
            assign right_byte = s_tdata;
        end
        else
        begin : g_inner
            assign right_byte = win_q[i+1];
        end

        srfr_win_cell u_cell
        (
            .clk        (clk),
            .ctl        (wctl[i]),
            .in_byte    (s_tdata),
            .right_byte (right_byte),
            .pat_byte   (pat_bytes_reg[i*BW +: BW]),
            .byte_q     (win_q[i]),
            .hit        (hits[i])
        );
    end

    always_comb
    begin
        if (pass)
        begin
            n_raw = CW'(1);
        end
        else if (match_now)
        begin
            n_raw = rep_eff;
        end
        else if (s_tlast)
        begin
            n_raw = CW'(fpos) + CW'(1);
        end
        else if (full)
        begin
            n_raw = CW'(1);
        end
        else
        begin
            n_raw = '0;
        end
        empty_now = s_tlast && (n_raw == '0);
    end

    assign octl.load  = acc;
    assign octl.shift = take;

    for (genvar k = 0; k < QD; k++)
    begin : g_out
        logic [BW-1:0] win_byte;
        logic [BW-1:0] right_byte;
        if (k < MAX_MATCH)
        begin : g_wsel
            assign win_byte = (FW'(k) < fpos) ? win_q[k] : s_tdata;
        end
        else
        begin : g_wnone
            assign win_byte = s_tdata;
        end
        if (k == QD - 1)
        begin : g_edge
            assign right_byte = '0;
        end
        else
        begin : g_inner
            assign right_byte = oq[k+1];
        end

        assign cand[k] = match_now ? rep_bytes_reg[k*BW +: BW] : win_byte;

        srfr_out_cell u_cell
        (
            .clk        (clk),
            .ctl        (octl),
            .load_byte  (cand[k]),
            .right_byte (right_byte),
            .byte_q     (oq[k])
        );
    end

    always_comb
    begin
        cnt_next = cnt_reg;
        if (acc)
        begin
            cnt_next = empty_now ? CW'(1) : n_raw;
        end
        else if (take)
        begin
            cnt_next = cnt_reg - CW'(1);
        end

        fill_next = fill_reg;
        seen_next = seen_reg;
        if (acc)
        begin
            if (s_tlast || match_now)
            begin
                fill_next = '0;
            end
            else if (!pass)
            begin
                fill_next = full ? fpos : (fpos + FW'(1));
            end
            seen_next = s_tlast ? 1'b0 : (seen_reg | match_now);
        end
        if (cfg_wr && (cfg_addr == srfr_pkg::CFG_MATCH_LENGTH))
        begin
            fill_next = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pat_bytes_reg <= '0;
            pat_len_reg   <= '0;
            rep_bytes_reg <= '0;
            rep_len_reg   <= '0;
            fill_reg      <= '0;
            seen_reg      <= 1'b0;
            cnt_reg       <= '0;
            empty_reg     <= 1'b0;
            eos_reg       <= 1'b0;
            any_reg       <= 1'b0;
            out_valid_reg <= 1'b0;
            out_data_reg  <= '0;
            out_user_reg  <= '0;
            out_last_reg  <= 1'b0;
        end
        else
        begin
            fill_reg <= fill_next;
            seen_reg <= seen_next;
            cnt_reg  <= cnt_next;
            if (acc)
            begin
                empty_reg <= empty_now;
                eos_reg   <= s_tlast;
                any_reg   <= seen_reg | match_now;
            end
            // result flags: last entry of a transaction burst carries the stream marks
            if (take)
            begin
                out_valid_reg   <= 1'b1;
                out_data_reg    <= empty_reg ? '0 : oq[0];
                out_user_reg[0] <= !empty_reg;
                out_user_reg[1] <= head_last;
                out_user_reg[2] <= eos_reg && head_last && any_reg;
                out_last_reg    <= eos_reg && head_last;
            end
            else if (m_tready)
            begin
                out_valid_reg <= 1'b0;
            end
            if (cfg_wr)
            begin
                case (cfg_addr)
                    srfr_pkg::CFG_MATCH_BYTES:    pat_bytes_reg <= cfg_data;
                    srfr_pkg::CFG_MATCH_LENGTH:   pat_len_reg   <= cfg_data[srfr_pkg::LEN_W-1:0];
                    srfr_pkg::CFG_REPLACE_BYTES:  rep_bytes_reg <= cfg_data;
                    srfr_pkg::CFG_REPLACE_LENGTH: rep_len_reg   <= cfg_data[srfr_pkg::LEN_W-1:0];
                    default:                      pat_len_reg   <= pat_len_reg;
                endcase
            end
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;
    assign m_tuser  = out_user_reg;
    assign m_tlast  = out_last_reg;

endmodule
